// File: sv/sdf_pkg.sv
package sdf_pkg;

  // Field widths fixed by the interface
  localparam int VALUE_W = 16;
  localparam int WIDTH_W = 6;
  localparam int CHAR_W  = 8;
  localparam int DIG_W   = 4;

  // Default size of the digit field
  localparam int MAX_DIGITS_DEF = 16;

  // ASCII codes
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT,
    ST_FLUSH
  } state_t;

  // Control from the sequencer to the binary-to-BCD shifter
  typedef struct packed {
    logic load;
    logic shift;
  } bcd_ctrl_t;

endpackage

// File: sv/sdf_bcd.sv
module sdf_bcd #(
  parameter int MAX_DIGITS = sdf_pkg::MAX_DIGITS_DEF
) (
  input  logic                                       clk,
  input  sdf_pkg::bcd_ctrl_t                         ctrl,
  input  logic [sdf_pkg::VALUE_W-1:0]                mag_in,
  output logic [MAX_DIGITS*sdf_pkg::DIG_W-1:0]       bcd_out
);
  import sdf_pkg::*;

  localparam int BCD_W = MAX_DIGITS * DIG_W;

  logic [VALUE_W-1:0] mag_r;
  logic [VALUE_W-1:0] mag_nxt;
  logic [BCD_W-1:0]   bcd_r;
  logic [BCD_W-1:0]   bcd_nxt;
  logic [BCD_W-1:0]   bcd_adj;

  // Add three to every digit of five or more before the shift
  always_comb begin
    for (int d = 0; d < MAX_DIGITS; d++) begin
      if (bcd_r[d*DIG_W +: DIG_W] >= DIG_W'(5)) begin
        bcd_adj[d*DIG_W +: DIG_W] = bcd_r[d*DIG_W +: DIG_W] + DIG_W'(3);
      end else begin
        bcd_adj[d*DIG_W +: DIG_W] = bcd_r[d*DIG_W +: DIG_W];
      end
    end
  end

  // Load the magnitude, or shift one bit into the BCD register
  always_comb begin
    mag_nxt = mag_r;
    bcd_nxt = bcd_r;
    if (ctrl.load) begin
      mag_nxt = mag_in;
      bcd_nxt = '0;
    end else if (ctrl.shift) begin
      mag_nxt = {mag_r[VALUE_W-2:0], 1'b0};
      bcd_nxt = {bcd_adj[BCD_W-2:0], mag_r[VALUE_W-1]};
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
  end

  assign bcd_out = bcd_r;

endmodule

// File: sv/signed_decimal_field_formatter.sv
// Signed decimal field formatter.
// Input channel (in_valid / in_stall) takes one request: a signed 16-bit
// value with show_sign, zero_pad and a signed field width. Output channel
// (out_valid / out_stall) returns its ASCII text one character per transfer,
// most significant first, with out_last high on the final character.
// After acceptance the magnitude is shifted bit by bit through a
// binary-to-BCD shift register. The sequencer then visits one digit
// position per cycle while the output does not stall, from the top of
// the field down (field length positions, MAX_DIGITS when the width is
// negative or larger), and ends in the flush state.
// A new request is taken only when the previous one has handed its last
// character to the output register, so the next conversion overlaps a
// stalled final character.
// One character is held back so that out_last is known when it leaves.
// A stall on the output freezes the position walk; nothing is dropped.
// rst_n (synchronous, active low) returns to idle and empties the output.
// A request that yields no characters (width zero, zero_pad, no sign)
// produces no output at all.
module signed_decimal_field_formatter #(
  parameter int MAX_DIGITS = sdf_pkg::MAX_DIGITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [sdf_pkg::VALUE_W-1:0] in_value,
  input  logic                               in_show_sign,
  input  logic                               in_zero_pad,
  input  logic signed [sdf_pkg::WIDTH_W-1:0] in_width,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [sdf_pkg::CHAR_W-1:0]         out_char_out,
  output logic                               out_last
);
  import sdf_pkg::*;

  localparam int BCD_W  = MAX_DIGITS * DIG_W;
  localparam int LEN_W  = $clog2(MAX_DIGITS + 1);
  localparam int POS_W  = $clog2(MAX_DIGITS);
  localparam int CNT_W  = $clog2(VALUE_W);

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     bitcnt_r;
  logic [LEN_W-1:0]     len_r;
  logic [POS_W-1:0]     pos_r;
  logic                 has_width_r;
  logic                 zero_r;
  logic                 suppress_r;
  logic [CHAR_W-1:0]    pend_r;
  logic                 pend_vld_r;
  logic                 out_valid_r;
  logic [CHAR_W-1:0]    out_char_r;
  logic                 out_last_r;

  logic                 accept;
  logic                 slot_free;
  logic                 step;
  logic                 conv_done;
  logic                 new_vld;
  logic [CHAR_W-1:0]    new_char;
  logic                 new_sup;
  logic                 push_last;
  logic [DIG_W-1:0]     cur_dig;
  logic [BCD_W-1:0]     bcd;
  logic [VALUE_W-1:0]   mag;
  logic [LEN_W-1:0]     len_in;
  logic [WIDTH_W-1:0]   width_u;
  bcd_ctrl_t            bcd_ctrl;

  // Binary-to-BCD shift register
  sdf_bcd #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_bcd (
    .clk     (clk),
    .ctrl    (bcd_ctrl),
    .mag_in  (mag),
    .bcd_out (bcd)
  );

  // Magnitude (16-bit unsigned meaning, -32768 fits) and field length
  assign mag     = in_value[VALUE_W-1] ? (~in_value + VALUE_W'(1)) : in_value;
  assign width_u = in_width;
  always_comb begin
    if (width_u[WIDTH_W-1] || (width_u > WIDTH_W'(MAX_DIGITS))) begin
      len_in = LEN_W'(MAX_DIGITS);
    end else begin
      len_in = width_u[LEN_W-1:0];
    end
  end

  assign slot_free = !out_valid_r || !out_stall;
  assign conv_done = (bitcnt_r == CNT_W'(VALUE_W - 1));
  assign cur_dig   = bcd[{pos_r, 2'b00} +: DIG_W];

  // Outputs of the sequencer: handshake, shifter control, next character
  always_comb begin
    in_stall       = 1'b1;
    bcd_ctrl.load  = 1'b0;
    bcd_ctrl.shift = 1'b0;
    step           = 1'b0;
    new_vld        = 1'b0;
    new_char       = CH_ZERO;
    new_sup        = suppress_r;
    push_last      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall      = 1'b0;
        bcd_ctrl.load = in_valid;
      end
      ST_CONV: begin
        bcd_ctrl.shift = 1'b1;
      end
      ST_EMIT: begin
        step = slot_free;
        if ((cur_dig == '0) && suppress_r) begin
          new_vld  = has_width_r &&
                     (!zero_r || ((LEN_W'(pos_r) + LEN_W'(1)) != len_r));
          new_char = CH_SPACE;
        end else begin
          new_vld  = 1'b1;
          new_char = CH_ZERO | {{(CHAR_W-DIG_W){1'b0}}, cur_dig};
          new_sup  = 1'b0;
        end
      end
      ST_FLUSH: begin
        step = slot_free;
        if (suppress_r) begin
          new_vld  = 1'b1;
          new_char = CH_ZERO;
          new_sup  = 1'b0;
        end else begin
          push_last = pend_vld_r;
        end
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign accept = in_valid && !in_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (conv_done) begin
          state_nxt = (len_r == '0) ? ST_FLUSH : ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (step && (pos_r == '0)) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!suppress_r && (slot_free || !pend_vld_r)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      suppress_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        pend_vld_r <= in_show_sign;
        suppress_r <= !in_zero_pad;
      end else if (step) begin
        suppress_r <= new_sup;
        if (new_vld) begin
          pend_vld_r <= 1'b1;
        end else if (push_last) begin
          pend_vld_r <= 1'b0;
        end
      end
      // Release the held character when a newer one arrives or at the end
      if (step && ((new_vld && pend_vld_r) || push_last)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      len_r       <= len_in;
      has_width_r <= !width_u[WIDTH_W-1];
      zero_r      <= (in_value == '0);
      pend_r      <= in_value[VALUE_W-1] ? CH_MINUS : CH_PLUS;
      bitcnt_r    <= '0;
    end
    if (state_r == ST_CONV) begin
      bitcnt_r <= bitcnt_r + CNT_W'(1);
      pos_r    <= POS_W'(len_r - LEN_W'(1));
    end
    if (step && (state_r == ST_EMIT)) begin
      pos_r <= pos_r - POS_W'(1);
    end
    if (step && new_vld) begin
      pend_r <= new_char;
    end
    if (step && ((new_vld && pend_vld_r) || push_last)) begin
      out_char_r <= pend_r;
      out_last_r <= push_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_char_out = out_char_r;
  assign out_last     = out_last_r;

`ifndef SYNTHESIS
  // An accepted request always starts the conversion
  a_accept_conv: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_CONV))
    else $error("accepted request did not start conversion");

  // The digit walk stays inside the field
  a_pos_in_field: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (LEN_W'(pos_r) < len_r))
    else $error("digit position outside the field");

  // Only sign, space or decimal digit characters leave the block
  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_char_r == CH_PLUS) || (out_char_r == CH_MINUS) ||
                     (out_char_r == CH_SPACE) ||
                     ((out_char_r >= CH_ZERO) && (out_char_r <= (CH_ZERO + CHAR_W'(9))))))
    else $error("illegal output character");
`endif

endmodule
